/* hdl/dmd_pkg.sv */
// Package for the D-Bus message deframer: result type, error codes and header constants.
// No dependencies; the deframer modules use it by scoped names.
package dmd_pkg;

  // Sticky framing error codes
  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_ENDIAN = 2'd1,
    ERR_SIZE   = 2'd2
  } err_t;

  // One output beat
  typedef struct packed {
    logic [31:0] len;
    err_t        err;
    logic        last;
    logic        first;
    logic [7:0]  data;
  } result_t;

  localparam logic [7:0]  MARK_LITTLE   = 8'h6C;
  localparam logic [7:0]  MARK_BIG      = 8'h42;
  localparam logic [31:0] HDR_LAST_POS  = 32'd15;
  localparam logic [31:0] BASE_POS      = 32'd8;
  localparam logic [29:0] BODY_WORD     = 30'd1;
  localparam logic [29:0] FIELDS_WORD   = 30'd3;
  localparam logic [31:0] MIN_LEN       = 32'd24;
  localparam logic [32:0] HDR_BYTES     = 33'd16;
  localparam logic [32:0] ALIGN_MASK    = 33'd7;
  localparam logic [32:0] MAX_SIZE_RST  = 33'd134217728;
  localparam logic [32:0] MAX_SIZE_TOP  = 33'h1_0000_0000;

endpackage

/* hdl/dmd_core.sv */
// Per-byte header tracking for the D-Bus message deframer: position counter, length capture,
// total computation and sticky error. Depends on dmd_pkg.
module dmd_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        rx_byte,
  input  logic [32:0]       max_size,
  output dmd_pkg::result_t  res
);

  logic [31:0]       byte_position, byte_position_next;
  logic [7:0]        endian_mark, endian_mark_next;
  logic [31:0]       body_length, body_length_next;
  logic [31:0]       fields_length, fields_length_next;
  logic [31:0]       total_length, total_length_next;
  logic [32:0]       base_length, base_length_next;
  dmd_pkg::err_t     error_code, error_code_next;

  logic [1:0]        lane;
  logic [31:0]       byte_shifted;
  logic [32:0]       fields_aligned;
  logic [33:0]       sum;

  // Byte lane within the 32-bit length word, by endian mark
  assign lane = (endian_mark == dmd_pkg::MARK_BIG) ? ~byte_position[1:0] : byte_position[1:0];
  assign byte_shifted = {24'd0, rx_byte} << {lane, 3'b000};

  // Total = 16 + body + align8(fields), with 16 + body captured earlier
  assign fields_aligned = ({1'b0, fields_length_next} + dmd_pkg::ALIGN_MASK) &
                          ~dmd_pkg::ALIGN_MASK;
  assign sum = {1'b0, base_length} + {1'b0, fields_aligned};

  // Next state and result for the byte at the input
  always_comb begin
    byte_position_next = byte_position;
    endian_mark_next   = endian_mark;
    body_length_next   = body_length;
    fields_length_next = fields_length;
    total_length_next  = total_length;
    base_length_next   = base_length;
    error_code_next    = error_code;
    res.data  = rx_byte;
    res.first = 1'b0;
    res.last  = 1'b0;
    res.len   = dmd_pkg::MIN_LEN;

    if (error_code != dmd_pkg::ERR_NONE) begin
      res.len = total_length;
    end else begin
      if (byte_position == 32'd0) begin
        res.first          = 1'b1;
        endian_mark_next   = rx_byte;
        body_length_next   = 32'd0;
        fields_length_next = 32'd0;
      end else if (byte_position[31:2] == dmd_pkg::BODY_WORD) begin
        body_length_next = body_length | byte_shifted;
      end else if (byte_position[31:2] == dmd_pkg::FIELDS_WORD) begin
        fields_length_next = fields_length | byte_shifted;
      end

      if (byte_position == dmd_pkg::BASE_POS) begin
        base_length_next = {1'b0, body_length} + dmd_pkg::HDR_BYTES;
      end

      // Check the header on its last byte
      if (byte_position == dmd_pkg::HDR_LAST_POS) begin
        if (endian_mark != dmd_pkg::MARK_LITTLE && endian_mark != dmd_pkg::MARK_BIG) begin
          error_code_next   = dmd_pkg::ERR_ENDIAN;
          total_length_next = 32'd0;
        end else if (sum >= {1'b0, max_size}) begin
          error_code_next   = dmd_pkg::ERR_SIZE;
          total_length_next = (sum[33:32] != 2'd0) ? 32'hFFFF_FFFF : sum[31:0];
        end else begin
          total_length_next = sum[31:0];
        end
      end

      if (error_code_next != dmd_pkg::ERR_NONE) begin
        res.len = total_length_next;
      end else if (byte_position >= dmd_pkg::HDR_LAST_POS) begin
        res.len = total_length_next;
        if (({1'b0, byte_position} + 33'd1) >= {1'b0, total_length_next}) begin
          res.last           = 1'b1;
          byte_position_next = 32'd0;
        end else begin
          byte_position_next = byte_position + 32'd1;
        end
      end else begin
        byte_position_next = byte_position + 32'd1;
      end
    end
    res.err = error_code_next;
  end

  // Advance state on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 32'd0;
      endian_mark   <= 8'd0;
      body_length   <= 32'd0;
      fields_length <= 32'd0;
      total_length  <= 32'd0;
      base_length   <= 33'd0;
      error_code    <= dmd_pkg::ERR_NONE;
    end else if (accept) begin
      byte_position <= byte_position_next;
      endian_mark   <= endian_mark_next;
      body_length   <= body_length_next;
      fields_length <= fields_length_next;
      total_length  <= total_length_next;
      base_length   <= base_length_next;
      error_code    <= error_code_next;
    end
  end

endmodule

/* hdl/dmd_out_reg.sv */
// Output register stage for the D-Bus message deframer: holds one result beat.
// Depends on dmd_pkg.
module dmd_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  dmd_pkg::result_t  res_in,
  input  logic              take,
  output logic              full,
  output dmd_pkg::result_t  res_out
);

  logic             valid;
  dmd_pkg::result_t held;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  // Capture payload
  always_ff @(posedge clk) begin
    if (load) begin
      held <= res_in;
    end
  end

  assign full    = valid;
  assign res_out = held;

endmodule

/* hdl/dbus_message_deframer.sv */
// A byte accepted at an edge is registered and appears on the master side right after that edge.
// Throughput: one byte per cycle while m_axis_tready stays high, set by the single output register
// and the per-byte header update. The slave side is ready whenever the output register is empty or
// being drained the same cycle. Reset (rst, synchronous): clears position, lengths and the sticky error,
// empties the output register and sets max_message_size to 134217728. Config writes are always taken.
// Top level of the D-Bus message deframer; depends on dmd_pkg, dmd_core and dmd_out_reg.
module dbus_message_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [7:0] out_byte, [39:8] message_length
  output logic [2:0]  m_axis_tuser,   // [0] first_of_message, [2:1] frame_error
  output logic        m_axis_tlast,   // last_of_message
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [32:0] cfg_data        // max_message_size
);

  logic [32:0]      max_size;
  logic             accept;
  logic             out_full;
  logic             out_take;
  dmd_pkg::result_t res_core;
  dmd_pkg::result_t res_out;

  // Size limit register, clamped to 2^32
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      max_size <= dmd_pkg::MAX_SIZE_RST;
    end else if (cfg_valid) begin
      max_size <= (cfg_data > dmd_pkg::MAX_SIZE_TOP) ? dmd_pkg::MAX_SIZE_TOP : cfg_data;
    end
  end

  // Accept a beat when the output slot is free or draining
  assign out_take      = out_full & m_axis_tready;
  assign s_axis_tready = ~out_full | m_axis_tready;
  assign accept        = s_axis_tvalid & s_axis_tready;

  dmd_core u_core (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .rx_byte  (s_axis_tdata),
    .max_size (max_size),
    .res      (res_core)
  );

  dmd_out_reg u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (accept),
    .res_in  (res_core),
    .take    (out_take),
    .full    (out_full),
    .res_out (res_out)
  );

  // Drive the master side
  assign m_axis_tvalid = out_full;
  assign m_axis_tdata  = {res_out.len, res_out.data};
  assign m_axis_tuser  = {res_out.err, res_out.first};
  assign m_axis_tlast  = res_out.last;

endmodule

/* verif/tb_dbus_message_deframer.sv */
// Self-checking bench for the D-Bus message deframer: feeds framed byte streams under several
// size limits, predicts every output beat and compares it field by field.
// Depends on dmd_pkg and the dbus_message_deframer RTL.
module tb_dbus_message_deframer;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;    // [7:0] rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;    // [7:0] out_byte, [39:8] message_length
  logic [2:0]  m_axis_tuser;    // [0] first_of_message, [2:1] frame_error
  logic        m_axis_tlast;    // last_of_message
  logic        cfg_valid;
  logic        cfg_ready;
  logic [32:0] cfg_data;        // max_message_size

  dbus_message_deframer u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  // Shadow copy of the deframer state
  logic [32:0]     size_limit;
  logic [31:0]     byte_pos;
  logic [31:0]     body_len;
  logic [31:0]     fields_len;
  logic [31:0]     total_len;
  logic [7:0]      hdr_mark;
  dmd_pkg::err_t   sticky_err;

  dmd_pkg::result_t frame_q[$];  // predicted output beats, oldest first
  logic [7:0]  byte_q[$];       // stream bytes waiting to be offered
  int          send_idle;
  int          recv_idle;
  int          mismatches;
  logic        beat_taken;
  logic        hold_off;
  logic        traffic_on;

  always begin
    clk = 1'b0;
    #5ns;
    clk = 1'b1;
    #5ns;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s got %0h want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // 16 + fields padded to 8 bytes + body, wide enough never to wrap
  function automatic logic [33:0] frame_total(input logic [31:0] fields, input logic [31:0] body);
    return 34'(dmd_pkg::HDR_BYTES) +
           ((34'(fields) + 34'(dmd_pkg::ALIGN_MASK)) & ~34'(dmd_pkg::ALIGN_MASK)) + 34'(body);
  endfunction

  // Place one length byte according to the endian mark
  function automatic logic [31:0] merge_byte(input logic [31:0] acc, input logic [1:0] off,
                                             input logic [7:0] b, input logic [7:0] mark);
    logic [4:0] sh;
    sh = (mark == dmd_pkg::MARK_BIG) ? {2'd3 - off, 3'b000} : {off, 3'b000};
    return acc | (32'(b) << sh);
  endfunction

  // Advance the shadow state by one byte and return the beat it produces
  function automatic dmd_pkg::result_t deframe_byte(input logic [7:0] b);
    dmd_pkg::result_t r;
    logic [31:0] pos;
    logic [32:0] lim;
    logic [33:0] sum;
    r = '0;
    r.data = b;
    if (sticky_err != dmd_pkg::ERR_NONE) begin
      r.len = total_len;
    end else begin
      pos = byte_pos;
      r.len = dmd_pkg::MIN_LEN;
      if (pos == 32'd0) begin
        r.first = 1'b1;
        hdr_mark = b;
        body_len = '0;
        fields_len = '0;
      end else if (pos[31:2] == dmd_pkg::BODY_WORD) begin
        body_len = merge_byte(body_len, pos[1:0], b, hdr_mark);
      end else if (pos[31:2] == dmd_pkg::FIELDS_WORD) begin
        fields_len = merge_byte(fields_len, pos[1:0], b, hdr_mark);
      end
      // judge the header on its last byte
      if (pos == dmd_pkg::HDR_LAST_POS) begin
        if (hdr_mark != dmd_pkg::MARK_LITTLE && hdr_mark != dmd_pkg::MARK_BIG) begin
          sticky_err = dmd_pkg::ERR_ENDIAN;
          total_len = '0;
        end else begin
          lim = (size_limit > dmd_pkg::MAX_SIZE_TOP) ? dmd_pkg::MAX_SIZE_TOP : size_limit;
          sum = frame_total(fields_len, body_len);
          if (sum >= 34'(lim)) begin
            sticky_err = dmd_pkg::ERR_SIZE;
            total_len = (sum > 34'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
          end else begin
            total_len = sum[31:0];
          end
        end
      end
      if (sticky_err != dmd_pkg::ERR_NONE) begin
        r.len = total_len;
      end else if (pos >= dmd_pkg::HDR_LAST_POS) begin
        r.len = total_len;
        if (33'(pos) + 33'd1 >= 33'(total_len)) begin
          r.last = 1'b1;
          byte_pos = '0;
        end else begin
          byte_pos = pos + 32'd1;
        end
      end else begin
        byte_pos = pos + 32'd1;
      end
    end
    r.err = sticky_err;
    return r;
  endfunction

  // Check outgoing beats, then predict the beat for each byte taken
  always @(posedge clk) begin : scoreboard
    dmd_pkg::result_t got;
    dmd_pkg::result_t want;
    if (rst) begin
      beat_taken <= 1'b0;
    end else begin
      beat_taken <= s_axis_tvalid && s_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[39:8], m_axis_tuser[2:1], m_axis_tlast, m_axis_tuser[0],
               m_axis_tdata[7:0]};
        if (frame_q.size() == 0) begin
          report_mismatch("beat with nothing expected, out_byte", 32'(got.data), 32'd0);
        end else begin
          want = frame_q.pop_front();
          if (got.data !== want.data)
            report_mismatch("out_byte", 32'(got.data), 32'(want.data));
          if (got.first !== want.first)
            report_mismatch("first_of_message", 32'(got.first), 32'(want.first));
          if (got.last !== want.last)
            report_mismatch("last_of_message", 32'(got.last), 32'(want.last));
          if (got.err !== want.err)
            report_mismatch("frame_error", 32'(got.err), 32'(want.err));
          if (got.len !== want.len)
            report_mismatch("message_length", got.len, want.len);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        frame_q.push_back(deframe_byte(s_axis_tdata));
    end
  end

  // Offer the next byte, or hold the current one until it is taken
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || beat_taken) begin
      if (byte_q.size() != 0 && $urandom_range(99, 0) >= send_idle) begin
        s_axis_tdata  <= byte_q.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Stall the output side at random
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !hold_off && ($urandom_range(99, 0) >= recv_idle);
    end
  end

  // Hold off the output long enough to back up the input
  initial begin
    hold_off = 1'b0;
    wait (traffic_on);
    repeat (40) @(posedge clk);
    hold_off = 1'b1;
    repeat (90) @(posedge clk);
    hold_off = 1'b0;
  end

  task automatic wait_idle();
    while (byte_q.size() != 0 || s_axis_tvalid || frame_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [32:0] value);
    wait_idle();
    @(negedge clk);
    cfg_data  = value;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    size_limit = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic push_word(input logic [31:0] w, input logic big);
    for (int i = 0; i < 4; i++)
      byte_q.push_back(big ? w[8*(3-i) +: 8] : w[8*i +: 8]);
  endtask

  // Queue a header with random filler, then tail random bytes
  task automatic queue_message(input logic [7:0] mark, input logic [31:0] fields,
                               input logic [31:0] body, input int tail);
    logic big;
    big = (mark == dmd_pkg::MARK_BIG);
    byte_q.push_back(mark);
    repeat (3) byte_q.push_back(8'($urandom));
    push_word(body, big);
    repeat (4) byte_q.push_back(8'($urandom));
    push_word(fields, big);
    repeat (tail) byte_q.push_back(8'($urandom));
  endtask

  // Queue well-formed messages whose totals stay under the limit
  task automatic queue_traffic(input logic [32:0] lim, input int f_hi, input int b_hi,
                               input int nbytes);
    logic [31:0] f;
    logic [31:0] b;
    logic [33:0] tot;
    int          queued;
    queued = 0;
    while (queued < nbytes) begin
      do begin
        f = $urandom_range(f_hi, 0);
        b = $urandom_range(b_hi, 0);
        tot = frame_total(f, b);
      end while (tot >= 34'(lim));
      queue_message($urandom_range(1, 0) ? dmd_pkg::MARK_BIG : dmd_pkg::MARK_LITTLE, f, b,
                    int'(tot - 34'(dmd_pkg::HDR_BYTES)));
      queued += int'(tot);
    end
  endtask

  initial begin : stimulus
    logic [32:0] lim;
    logic [7:0]  mark;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    send_idle     = 21;
    recv_idle     = 45;
    mismatches    = 0;
    traffic_on    = 1'b0;
    size_limit    = dmd_pkg::MAX_SIZE_RST;
    byte_pos      = '0;
    body_len      = '0;
    fields_len    = '0;
    total_len     = '0;
    hdr_mark      = '0;
    sticky_err    = dmd_pkg::ERR_NONE;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // shortest message, header byte 15 closes it; filler at both byte extremes
    byte_q = {dmd_pkg::MARK_LITTLE, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
              8'hFF, 8'h80, 8'h7F, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00};
    traffic_on = 1'b1;
    queue_traffic(dmd_pkg::MAX_SIZE_RST, 20, 40, 20);

    // lowest limit: only totals 16 to 23 pass, 23 right at the edge
    write_limit(33'(dmd_pkg::MIN_LEN));
    queue_message(dmd_pkg::MARK_BIG, 32'd0, 32'd7, 7);
    queue_traffic(33'(dmd_pkg::MIN_LEN), 1, 9, 20);

    // limits above the 32-bit range clamp to 2^32
    send_idle = 45;
    recv_idle = 21;
    write_limit(33'h1_FFFF_FFFF);
    queue_traffic(33'h1_FFFF_FFFF, 20, 40, 20);
    write_limit(dmd_pkg::MAX_SIZE_TOP);
    queue_traffic(dmd_pkg::MAX_SIZE_TOP, 20, 40, 20);

    // no idling from here on; small limit with a message one byte under it
    send_idle = 0;
    recv_idle = 0;
    lim = 33'($urandom_range(120, 40));
    write_limit(lim);
    queue_message(dmd_pkg::MARK_LITTLE, 32'd0, 32'(lim) - 32'd17, int'(lim) - 17);
    queue_traffic(lim, 20, 40, 20);
    lim = {1'($urandom), 32'($urandom)} | 33'h1000;
    write_limit(lim);
    queue_traffic(lim, 20, 40, 20);

    // close with a header that raises the sticky error, then noise that must carry it
    lim = 33'($urandom_range(300, 24));
    write_limit(lim);
    queue_traffic(lim, 20, 40, 20);
    case ($urandom_range(2, 0))
      0: begin
        do mark = 8'($urandom);
        while (mark == dmd_pkg::MARK_LITTLE || mark == dmd_pkg::MARK_BIG);
        queue_message(mark, $urandom, $urandom, 30);
      end
      1: begin
        // total lands exactly on the limit
        queue_message(dmd_pkg::MARK_BIG, 32'd0, 32'(lim) - 32'd16, 30);
      end
      default: begin
        // sum overflows 32 bits and saturates
        queue_message(dmd_pkg::MARK_LITTLE, $urandom | 32'h8000_0000,
                      $urandom | 32'h8000_0000, 30);
      end
    endcase

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
